// ----- design/hps_pkg.sv -----
// Package for the haptic pattern sequencer: payload structs, op codes,
// status codes, mode codes and sequencer state encoding. No dependencies.
package hps_pkg;

  // Number of pattern table entries.
  localparam int MAX_PATTERNS = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_MODE     = 4'd1;
  localparam logic [3:0] ST_RUN_MODE = 4'd2;
  localparam logic [3:0] ST_COUNT    = 4'd3;
  localparam logic [3:0] ST_PHASE    = 4'd4;
  localparam logic [3:0] ST_REPEAT   = 4'd5;
  localparam logic [3:0] ST_INTERVAL = 4'd6;
  localparam logic [3:0] ST_STEP     = 4'd7;
  localparam logic [3:0] ST_RAMPTYPE = 4'd8;
  localparam logic [3:0] ST_LEVEL    = 4'd9;

  localparam logic [2:0] REG_EXEC_MODE     = 3'd0;
  localparam logic [2:0] REG_RUN_MODE      = 3'd1;
  localparam logic [2:0] REG_RAMP_TYPE     = 3'd2;
  localparam logic [2:0] REG_START_LEVEL   = 3'd3;
  localparam logic [2:0] REG_LEVEL_STEP    = 3'd4;
  localparam logic [2:0] REG_RAMP_INTERVAL = 3'd5;
  localparam logic [2:0] REG_PATTERN_COUNT = 3'd6;

  localparam logic [1:0] EXEC_OFF   = 2'd0;
  localparam logic [1:0] EXEC_CONST = 2'd1;
  localparam logic [1:0] EXEC_UP    = 2'd2;
  localparam logic [1:0] EXEC_DOWN  = 2'd3;
  localparam logic [1:0] RUN_OFF     = 2'd0;
  localparam logic [1:0] RUN_ONCE    = 2'd1;
  localparam logic [1:0] RUN_RESTART = 2'd2;
  localparam logic [1:0] RUN_RSVD    = 2'd3;
  localparam logic [1:0] RAMP_OFF    = 2'd0;
  localparam logic [1:0] RAMP_WRAP   = 2'd1;
  localparam logic [1:0] RAMP_CLAMP  = 2'd2;
  localparam logic [1:0] RAMP_RSVD   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  entry_index;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [7:0]  repeat_count;
  } hps_in_t;

  typedef struct packed {
    logic        motor_on;
    logic [6:0]  duty_level;
    logic        running;
    logic [3:0]  status;
  } hps_out_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_FINAL  = 8'b0001_0000,
    S_TPHASE = 8'b0010_0000,
    S_TREST  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

endpackage

// ----- design/haptic_pattern_sequencer_top.sv -----
// Haptic pattern sequencer top level: pattern table memory, start-check
// walker with a shared multiplier, and the millisecond tick sequencer. Uses hps_pkg.
//
// Steps from acceptance to result: a tick on a running sequence goes through table
// read, phase update, ramp/total and output; an idle tick, a write or a stop goes
// straight to output; a start checks, reads and multiplies each entry in turn, then
// runs the final checks and the output. One item at a time; ready is low while an
// item is in work and while a result waits, and comes back the cycle after the
// result is taken. The registered table read and the 16x8 multiply set these steps.
// Reset (synchronous, active high) clears the sequencer and registers to
// their defaults; the table itself holds undefined contents until written.
module haptic_pattern_sequencer_top
  import hps_pkg::*;
#(
  parameter int LEVEL_MAX            = 100,
  parameter int LEVEL_MIN            = 0,
  parameter int PHASE_MIN_MS         = 1,
  parameter int PHASE_MAX_MS         = 10000,
  parameter int RAMP_INTERVAL_MAX_MS = 10000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hps_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hps_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

  // Configuration registers.
  logic [1:0]  exec_mode, run_mode, ramp_type;
  logic [6:0]  start_level;
  logic [7:0]  level_step;
  logic [15:0] ramp_interval_ms;
  logic [3:0]  pattern_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_mode        <= EXEC_CONST;
      run_mode         <= RUN_ONCE;
      ramp_type        <= RAMP_WRAP;
      start_level      <= 7'd100;
      level_step       <= 8'd0;
      ramp_interval_ms <= 16'd0;
      pattern_count    <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXEC_MODE:     exec_mode        <= cfg_data[1:0];
        REG_RUN_MODE:      run_mode         <= cfg_data[1:0];
        REG_RAMP_TYPE:     ramp_type        <= cfg_data[1:0];
        REG_START_LEVEL:   start_level      <= cfg_data[6:0];
        REG_LEVEL_STEP:    level_step       <= cfg_data[7:0];
        REG_RAMP_INTERVAL: ramp_interval_ms <= cfg_data;
        REG_PATTERN_COUNT: pattern_count    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Pattern table: {on, off, repeat}, one write and one registered read port.
  logic [39:0] table_mem [MAX_PATTERNS];
  logic [39:0] rd_data;
  logic [AW-1:0] rd_addr;

  state_t  state;
  logic    is_ramp;
  assign is_ramp = (exec_mode == EXEC_UP) || (exec_mode == EXEC_DOWN);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.op == OP_WRITE &&
        32'(in_data.entry_index) < MAX_PATTERNS)
      table_mem[in_data.entry_index[AW-1:0]] <=
        {in_data.on_ms, in_data.off_ms, in_data.repeat_count};
    rd_data <= table_mem[rd_addr];
  end

  logic [15:0] e_on, e_off;
  logic [7:0]  e_rep;
  assign e_on  = rd_data[39:24];
  assign e_off = rd_data[23:8];
  assign e_rep = rd_data[7:0];

  // Sequencer state.
  logic        in_on_phase, seq_running;
  logic [7:0]  cycle_counter;
  logic [3:0]  entry_pointer;
  logic [9:0]  ramp_level;
  logic [6:0]  applied_level;
  logic [15:0] phase_timer, ramp_timer, total_timer, total_duration;
  logic [3:0]  status;
  logic [3:0]  walk;
  logic [15:0] sum, mul_a;
  logic [7:0]  mul_b;
  logic        out_pending;

  logic entry_live;
  assign entry_live = (entry_pointer < pattern_count) &&
                      (32'(entry_pointer) < MAX_PATTERNS);

  // Address selection: walker index during start, entry pointer otherwise.
  always_comb begin
    if (state == S_CHECK || state == S_MUL)
      rd_addr = walk[AW-1:0];
    else
      rd_addr = entry_pointer[AW-1:0];
  end

  function automatic logic [9:0] clamp_pct(input logic [9:0] v);
    return (32'(v) > LEVEL_MAX) ? 10'(LEVEL_MAX) : v;
  endfunction

  // Full reset of the run state to idle.
  task automatic idle_all();
    in_on_phase   <= 1'b0;
    seq_running   <= 1'b0;
    cycle_counter <= '0;
    entry_pointer <= '0;
    ramp_level    <= 10'(LEVEL_MAX);
    applied_level <= 7'(LEVEL_MAX);
    phase_timer   <= '0;
    ramp_timer    <= '0;
    total_timer   <= '0;
  endtask

  logic        live0;
  logic [9:0]  lvl0;
  logic [16:0] phsum;
  logic [15:0] plen, ph_inc, rt_inc, tt_inc;
  logic [10:0] up_v;
  logic [9:0]  rl_next;
  assign live0  = (4'd0 < pattern_count) && (MAX_PATTERNS > 0);
  assign lvl0   = is_ramp ? {3'd0, start_level} : 10'(LEVEL_MAX);
  assign phsum  = {1'b0, e_on} + {1'b0, e_off};
  assign plen   = in_on_phase ? e_on : e_off;
  assign ph_inc = phase_timer + 16'd1;
  assign rt_inc = ramp_timer + 16'd1;
  assign tt_inc = total_timer + 16'd1;
  assign up_v   = {1'b0, ramp_level} + {3'd0, level_step};

  always_comb begin
    rl_next = ramp_level;
    if (exec_mode == EXEC_UP) begin
      if (32'(up_v) > LEVEL_MAX)
        rl_next = (ramp_type == RAMP_WRAP) ? {3'd0, start_level} : 10'(LEVEL_MAX);
      else
        rl_next = up_v[9:0];
    end else if (exec_mode == EXEC_DOWN) begin
      if (32'(ramp_level) < LEVEL_MIN + 32'(level_step))
        rl_next = (ramp_type == RAMP_WRAP) ? {3'd0, start_level} : 10'(LEVEL_MIN);
      else
        rl_next = ramp_level - {2'd0, level_step};
    end
  end

  assign in_ready  = (state == S_IDLE) && !out_pending;
  assign out_valid = out_pending;
  assign out_data  = '{motor_on: seq_running && in_on_phase,
                       duty_level: applied_level,
                       running: seq_running,
                       status: status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_pending    <= 1'b0;
      total_duration <= '0;
      status         <= ST_OK;
      walk           <= '0;
      sum            <= '0;
      idle_all();
    end else begin
      if (out_valid && out_ready) out_pending <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            status <= ST_OK;
            case (in_data.op)
              OP_TICK:  state <= seq_running ? S_READ : S_OUT;
              OP_WRITE: state <= S_OUT;
              OP_STOP: begin
                idle_all();
                state <= S_OUT;
              end
              default: begin
                idle_all();
                walk  <= '0;
                sum   <= '0;
                state <= S_CHECK;
              end
            endcase
          end
        end
        S_CHECK: begin
          // Global checks on entry; the table read for walk issues meanwhile.
          if (walk == 4'd0 && exec_mode == EXEC_OFF) begin
            status <= ST_MODE; state <= S_OUT;
          end else if (walk == 4'd0 && (run_mode inside {RUN_OFF, RUN_RSVD})) begin
            status <= ST_RUN_MODE; state <= S_OUT;
          end else if (walk == 4'd0 &&
                       (pattern_count == 4'd0 || 32'(pattern_count) > MAX_PATTERNS)) begin
            status <= ST_COUNT; state <= S_OUT;
          end else if (walk == pattern_count || 32'(walk) >= MAX_PATTERNS) begin
            state <= S_FINAL;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (32'(e_on) > PHASE_MAX_MS || 32'(e_on) < PHASE_MIN_MS ||
              32'(e_off) > PHASE_MAX_MS || 32'(e_off) < PHASE_MIN_MS) begin
            status <= ST_PHASE; state <= S_OUT;
          end else if (e_rep == 8'd0) begin
            status <= ST_REPEAT; state <= S_OUT;
          end else begin
            mul_a <= phsum[15:0];
            mul_b <= e_rep;
            state <= S_FINAL;
            walk  <= walk + 4'd1;
          end
        end
        S_FINAL: begin
          // Accumulate the last product, then either walk on or finish.
          if (mul_b != 8'd0) begin
            sum   <= sum + 16'(mul_a * mul_b);
            mul_b <= 8'd0;
            state <= S_CHECK;
          end else if (is_ramp && (ramp_interval_ms == 16'd0 ||
                       32'(ramp_interval_ms) > RAMP_INTERVAL_MAX_MS)) begin
            status <= ST_INTERVAL; state <= S_OUT;
          end else if (is_ramp && 32'(level_step) > PHASE_MAX_MS) begin
            status <= ST_STEP; state <= S_OUT;
          end else if (is_ramp && (ramp_type inside {RAMP_OFF, RAMP_RSVD})) begin
            status <= ST_RAMPTYPE; state <= S_OUT;
          end else if (is_ramp && (32'(start_level) > LEVEL_MAX ||
                                   32'(start_level) < LEVEL_MIN)) begin
            status <= ST_LEVEL; state <= S_OUT;
          end else begin
            total_duration <= sum;
            seq_running    <= 1'b1;
            ramp_level     <= lvl0;
            in_on_phase    <= live0;
            applied_level  <= 7'(clamp_pct(lvl0));
            state          <= S_OUT;
          end
        end
        S_READ: state <= S_TPHASE;
        S_TPHASE: begin
          if (entry_live) begin
            if (ph_inc >= plen) begin
              phase_timer <= '0;
              if (in_on_phase) begin
                in_on_phase <= 1'b0;
                if (cycle_counter != 8'hFF) cycle_counter <= cycle_counter + 8'd1;
              end else if (cycle_counter >= e_rep) begin
                entry_pointer <= entry_pointer + 4'd1;
                cycle_counter <= '0;
                if ((entry_pointer + 4'd1) < pattern_count &&
                    32'(entry_pointer + 4'd1) < MAX_PATTERNS) begin
                  in_on_phase   <= 1'b1;
                  applied_level <= 7'(clamp_pct(ramp_level));
                end
              end else begin
                in_on_phase   <= 1'b1;
                applied_level <= 7'(clamp_pct(ramp_level));
              end
            end else begin
              phase_timer <= ph_inc;
            end
          end else begin
            in_on_phase <= 1'b0;
          end
          state <= S_TREST;
        end
        S_TREST: begin
          if (tt_inc >= total_duration) begin
            if (run_mode == RUN_RESTART) begin
              // Restart from the first entry with the stored total.
              in_on_phase   <= live0;
              seq_running   <= 1'b1;
              cycle_counter <= '0;
              entry_pointer <= '0;
              ramp_level    <= lvl0;
              applied_level <= 7'(clamp_pct(lvl0));
              phase_timer   <= '0;
              ramp_timer    <= '0;
              total_timer   <= '0;
            end else begin
              idle_all();
            end
          end else begin
            total_timer <= tt_inc;
            if (is_ramp) begin
              if (rt_inc >= ramp_interval_ms) begin
                ramp_timer <= '0;
                ramp_level <= rl_next;
              end else begin
                ramp_timer <= rt_inc;
              end
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_pending <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is only raised from the output step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_pending) |-> $past(state) == S_OUT)
    else $error("result raised outside output step");
  // No new item is accepted while a result is held.
  assert property (@(posedge clk) disable iff (rst)
    out_pending |-> !in_ready)
    else $error("item accepted while result pending");
  // The motor is never driven with the sequence stopped.
  assert property (@(posedge clk) disable iff (rst)
    out_data.motor_on |-> out_data.running)
    else $error("motor on while idle");
  // A non-zero status leaves the sequence idle.
  assert property (@(posedge clk) disable iff (rst)
    (out_pending && status != ST_OK) |-> !seq_running)
    else $error("running after failed start");

endmodule

// ----- test/tb_haptic_pattern_sequencer_top.sv -----
// Self-checking testbench for haptic_pattern_sequencer_top: directed and random items
// are checked against a cycle-free behavioral predictor. Depends on hps_pkg and the RTL.
`timescale 1ns / 100ps

module tb_haptic_pattern_sequencer_top;
  import hps_pkg::*;

  localparam int NUM_ENTRIES = 8;
  localparam int LVL_MAX     = 100;
  localparam int PH_MIN      = 1;
  localparam int PH_MAX      = 10000;
  localparam int INTV_MAX    = 10000;
  // The settle pause covers a start that walks all eight entries.
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 5000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  hps_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  hps_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  haptic_pattern_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The clock runs with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Expected results, oldest first, and the failure count.
  hps_out_t    pending_results[$];
  int unsigned mismatch_count;
  // When set, neither side inserts idle cycles.
  bit          steady_flow;

  // Predictor copy of the configuration registers.
  int unsigned cfg_exec, cfg_run, cfg_rtype, cfg_start, cfg_step, cfg_intv, cfg_count;

  // Predictor copy of the pattern table and of the sequencer state.
  int unsigned tbl_on[NUM_ENTRIES];
  int unsigned tbl_off[NUM_ENTRIES];
  int unsigned tbl_rep[NUM_ENTRIES];
  bit          seq_on_phase, seq_active;
  int unsigned seq_cycles, seq_ptr, seq_ramp, seq_applied;
  int unsigned seq_phase_t, seq_ramp_t, seq_total_t, seq_total_len;

  function automatic bit ramp_mode();
    return cfg_exec == EXEC_UP || cfg_exec == EXEC_DOWN;
  endfunction

  function automatic bit entry_in_use();
    return seq_ptr < cfg_count && seq_ptr < NUM_ENTRIES;
  endfunction

  function automatic void latch_duty();
    seq_applied = (seq_ramp > LVL_MAX) ? LVL_MAX : seq_ramp;
  endfunction

  function automatic void seq_clear();
    seq_on_phase = 1'b0;
    seq_active   = 1'b0;
    seq_cycles   = 0;
    seq_ptr      = 0;
    seq_ramp     = LVL_MAX;
    seq_applied  = LVL_MAX;
    seq_phase_t  = 0;
    seq_ramp_t   = 0;
    seq_total_t  = 0;
  endfunction

  function automatic void seq_launch();
    seq_clear();
    seq_active   = 1'b1;
    seq_ramp     = ramp_mode() ? cfg_start : LVL_MAX;
    seq_on_phase = entry_in_use();
    latch_duty();
  endfunction

  // Called when the current on or off phase runs out.
  function automatic void phase_done();
    if (seq_on_phase) begin
      seq_on_phase = 1'b0;
      if (seq_cycles < 255) seq_cycles++;
    end else if (seq_cycles >= tbl_rep[seq_ptr]) begin
      seq_ptr++;
      seq_cycles = 0;
      if (entry_in_use()) begin
        seq_on_phase = 1'b1;
        latch_duty();
      end
    end else begin
      seq_on_phase = 1'b1;
      latch_duty();
    end
  endfunction

  function automatic void ramp_advance();
    int unsigned lvl;
    if (cfg_exec == EXEC_UP) begin
      lvl = seq_ramp + cfg_step;
      if (lvl > LVL_MAX) lvl = (cfg_rtype == RAMP_WRAP) ? cfg_start : LVL_MAX;
      seq_ramp = lvl;
    end else if (cfg_exec == EXEC_DOWN) begin
      if (seq_ramp < cfg_step) seq_ramp = (cfg_rtype == RAMP_WRAP) ? cfg_start : 0;
      else seq_ramp = seq_ramp - cfg_step;
    end
  endfunction

  // One millisecond: phase end first, then the ramp step, then the total timeout.
  function automatic void ms_tick();
    int unsigned len;
    if (!seq_active) return;
    if (entry_in_use()) begin
      len = seq_on_phase ? tbl_on[seq_ptr] : tbl_off[seq_ptr];
      seq_phase_t++;
      if (seq_phase_t >= len) begin
        seq_phase_t = 0;
        phase_done();
      end
    end else begin
      seq_on_phase = 1'b0;
    end
    if (ramp_mode()) begin
      seq_ramp_t++;
      if (seq_ramp_t >= cfg_intv) begin
        seq_ramp_t = 0;
        ramp_advance();
      end
    end
    seq_total_t++;
    if (seq_total_t >= seq_total_len) begin
      if (cfg_run == RUN_RESTART) seq_launch();
      else seq_clear();
    end
  endfunction

  // Start command: validate, sum the wrapping total, and launch on success.
  function automatic logic [3:0] start_check();
    int unsigned sum;
    sum = 0;
    seq_clear();
    if (cfg_exec == EXEC_OFF) return ST_MODE;
    if (cfg_run == RUN_OFF || cfg_run == RUN_RSVD) return ST_RUN_MODE;
    if (cfg_count == 0 || cfg_count > NUM_ENTRIES) return ST_COUNT;
    for (int i = 0; i < cfg_count; i++) begin
      if (tbl_on[i] > PH_MAX || tbl_on[i] < PH_MIN) return ST_PHASE;
      if (tbl_off[i] > PH_MAX || tbl_off[i] < PH_MIN) return ST_PHASE;
      if (tbl_rep[i] == 0) return ST_REPEAT;
      sum = (sum + tbl_rep[i] * ((tbl_on[i] + tbl_off[i]) & 16'hFFFF)) & 16'hFFFF;
    end
    if (ramp_mode()) begin
      if (cfg_intv > INTV_MAX || cfg_intv < 1) return ST_INTERVAL;
      if (cfg_step > PH_MAX) return ST_STEP;
      if (cfg_rtype == RAMP_OFF || cfg_rtype == RAMP_RSVD) return ST_RAMPTYPE;
      if (cfg_start > LVL_MAX) return ST_LEVEL;
    end
    seq_total_len = sum;
    seq_launch();
    return ST_OK;
  endfunction

  function automatic hps_out_t predict_status(hps_in_t it);
    hps_out_t r;
    logic [3:0] st;
    st = ST_OK;
    case (it.op)
      OP_TICK:  ms_tick();
      OP_WRITE: begin
        tbl_on[it.entry_index]  = 32'(it.on_ms);
        tbl_off[it.entry_index] = 32'(it.off_ms);
        tbl_rep[it.entry_index] = 32'(it.repeat_count);
      end
      OP_START: st = start_check();
      default:  seq_clear();
    endcase
    r.motor_on   = seq_active && seq_on_phase;
    r.duty_level = seq_applied[6:0];
    r.running    = seq_active;
    r.status     = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    hps_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_data.motor_on !== want.motor_on)
          report_mismatch($sformatf("motor_on %0b, want %0b", out_data.motor_on, want.motor_on));
        if (out_data.duty_level !== want.duty_level)
          report_mismatch($sformatf("duty_level %0d, want %0d",
                                    out_data.duty_level, want.duty_level));
        if (out_data.running !== want.running)
          report_mismatch($sformatf("running %0b, want %0b", out_data.running, want.running));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
      end
    end
  end

  // The receiver stalls in about a third of the cycles unless the flow is steady.
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 34);
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Sends one item and returns at the edge where it is accepted, with valid still
  // high; the next send or a settle takes care of valid from there.
  task automatic send_item(input hps_in_t it);
    int unsigned gap;
    gap = (!steady_flow && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_status(it));
  endtask

  // Drops valid and waits until the block has answered everything.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_EXEC_MODE:     cfg_exec  = value & 3;
      REG_RUN_MODE:      cfg_run   = value & 3;
      REG_RAMP_TYPE:     cfg_rtype = value & 3;
      REG_START_LEVEL:   cfg_start = value & 8'h7F;
      REG_LEVEL_STEP:    cfg_step  = value & 8'hFF;
      REG_RAMP_INTERVAL: cfg_intv  = value & 16'hFFFF;
      REG_PATTERN_COUNT: cfg_count = value & 4'hF;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int unsigned ex, input int unsigned rn,
                             input int unsigned rt, input int unsigned sl,
                             input int unsigned stp, input int unsigned iv,
                             input int unsigned cnt);
    settle();
    write_reg(REG_EXEC_MODE, ex);
    write_reg(REG_RUN_MODE, rn);
    write_reg(REG_RAMP_TYPE, rt);
    write_reg(REG_START_LEVEL, sl);
    write_reg(REG_LEVEL_STEP, stp);
    write_reg(REG_RAMP_INTERVAL, iv);
    write_reg(REG_PATTERN_COUNT, cnt);
  endtask

  function automatic hps_in_t make_op(input op_t op);
    hps_in_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  function automatic hps_in_t make_entry(input int unsigned idx, input int unsigned on_t,
                                         input int unsigned off_t, input int unsigned rep);
    hps_in_t it;
    it.op           = OP_WRITE;
    it.entry_index  = 3'(idx);
    it.on_ms        = 16'(on_t);
    it.off_ms       = 16'(off_t);
    it.repeat_count = 8'(rep);
    return it;
  endfunction

  // Fills the whole table so that no later start or tick reads an unwritten entry,
  // and walks the per-entry start checks: the edges of the phase range and a zero repeat.
  task automatic test_table_checks();
    for (int i = 0; i < NUM_ENTRIES; i++) send_item(make_entry(i, 2, 1, 1));
    apply_setup(EXEC_CONST, RUN_ONCE, RAMP_WRAP, 100, 0, 0, 1);
    send_item(make_entry(0, 0, 5, 1));
    send_item(make_op(OP_START));
    send_item(make_entry(0, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(make_op(OP_START));
    send_item(make_entry(0, 3, 10001, 2));
    send_item(make_op(OP_START));
    send_item(make_entry(0, 10000, 1, 0));
    send_item(make_op(OP_START));
    send_item(make_entry(0, 3, 2, 2));
  endtask

  // Register checks: mode, run mode, count, interval, ramp type and start level.
  task automatic test_register_checks();
    apply_setup(EXEC_OFF, RUN_ONCE, RAMP_WRAP, 100, 0, 0, 1);
    send_item(make_op(OP_START));
    apply_setup(EXEC_CONST, RUN_OFF, RAMP_WRAP, 100, 0, 0, 1);
    send_item(make_op(OP_START));
    apply_setup(EXEC_CONST, RUN_RSVD, RAMP_WRAP, 100, 0, 0, 0);
    send_item(make_op(OP_START));
    apply_setup(EXEC_CONST, RUN_ONCE, RAMP_WRAP, 100, 0, 0, 15);
    send_item(make_op(OP_START));
    apply_setup(EXEC_UP, RUN_ONCE, RAMP_WRAP, 100, 255, 0, 8);
    send_item(make_op(OP_START));
    apply_setup(EXEC_UP, RUN_ONCE, RAMP_OFF, 100, 255, 10000, 8);
    send_item(make_op(OP_START));
    apply_setup(EXEC_DOWN, RUN_ONCE, RAMP_RSVD, 100, 255, 1, 9);
    send_item(make_op(OP_START));
    apply_setup(EXEC_DOWN, RUN_ONCE, RAMP_CLAMP, 127, 255, 65535, 2);
    send_item(make_op(OP_START));
    apply_setup(EXEC_DOWN, RUN_ONCE, RAMP_CLAMP, 101, 255, 1, 2);
    send_item(make_op(OP_START));
  endtask

  // Plays short patterns in ascending and descending modes with restart, and in constant mode once.
  task automatic test_playback();
    apply_setup(EXEC_UP, RUN_RESTART, RAMP_WRAP, 0, 30, 2, 2);
    send_item(make_op(OP_START));
    repeat (40) send_item(make_op(OP_TICK));
    send_item(make_op(OP_STOP));
    send_item(make_op(OP_TICK));
    apply_setup(EXEC_DOWN, RUN_RESTART, RAMP_CLAMP, 100, 45, 1, 3);
    send_item(make_op(OP_START));
    repeat (40) send_item(make_op(OP_TICK));
    apply_setup(EXEC_CONST, RUN_ONCE, RAMP_CLAMP, 0, 0, 0, 8);
    send_item(make_op(OP_START));
    repeat (60) send_item(make_op(OP_TICK));
  endtask

  function automatic hps_in_t random_item();
    hps_in_t it;
    int unsigned pick;
    it = '0;
    pick = $urandom_range(99);
    if (pick < 72) begin
      it.op = OP_TICK;
      it.entry_index = 3'($urandom);
    end else if (pick < 86) begin
      // Mostly short playable entries; now and then any value at all.
      if ($urandom_range(9) == 0)
        it = make_entry($urandom_range(7), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(255));
      else
        it = make_entry($urandom_range(7), $urandom_range(1, 4),
                        $urandom_range(1, 4), $urandom_range(1, 2));
    end else if (pick < 96) begin
      it.op = OP_START;
    end else begin
      it.op = OP_STOP;
    end
    return it;
  endfunction

  // Random phases: each picks a register setting, then streams random items.
  task automatic test_random_traffic();
    int unsigned ex, cnt, stp;
    for (int ph = 0; ph < 8; ph++) begin
      ex  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      cnt = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
      stp = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40);
      apply_setup(ex, $urandom_range(3), $urandom_range(3), $urandom_range(127),
                  stp, ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(1, 5),
                  cnt);
      // Repair the table so that the chosen count plays.
      for (int i = 0; i < NUM_ENTRIES; i++)
        send_item(make_entry(i, $urandom_range(1, 4), $urandom_range(1, 4),
                             $urandom_range(1, 2)));
      send_item(make_op(OP_START));
      steady_flow = (ph == 4);
      for (int n = 0; n < 82; n++) begin
        send_item(random_item());
        // Once per phase the sender holds off until every result is back.
        if (n == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    steady_flow    = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    // Predictor starts from the reset defaults.
    cfg_exec  = 32'(EXEC_CONST);
    cfg_run   = 32'(RUN_ONCE);
    cfg_rtype = 32'(RAMP_WRAP);
    cfg_start = 100;
    cfg_step  = 0;
    cfg_intv  = 0;
    cfg_count = 1;
    seq_total_len = 0;
    seq_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_checks();
    test_register_checks();
    test_playback();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- haptic_pattern_sequencer_top.f -----
design/hps_pkg.sv
design/haptic_pattern_sequencer_top.sv
test/tb_haptic_pattern_sequencer_top.sv
